// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/sbtsd_pkg.sv
// Shared types, constants and the symbol table of the six-bit text decoder.
package sbtsd_pkg;

	localparam int DEF_SAMPLE_WIDTH = 32;
	localparam int DEF_COUNT_WIDTH  = 24;
	localparam int DEF_QUEUE_DEPTH  = 4;

	// Raw byte codes tested before decoding
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Alphabet boundaries after the top bit is cleared
	localparam logic [6:0] CHAR_PLUS    = 7'h2B;
	localparam logic [6:0] CHAR_MINUS   = 7'h2D;
	localparam logic [6:0] CHAR_ZERO    = 7'h30;
	localparam logic [6:0] CHAR_NINE    = 7'h39;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

	localparam logic [6:0] SYM_PLUS       = 7'd0;
	localparam logic [6:0] SYM_MINUS      = 7'd1;
	localparam logic [6:0] SYM_DIGIT_BASE = 7'd2;
	localparam logic [6:0] SYM_UPPER_BASE = 7'd12;
	localparam logic [6:0] SYM_LOWER_BASE = 7'd38;

	// Bit positions inside a symbol
	localparam int SIGN_POS = 4;
	localparam int CONT_POS = 5;

	typedef struct packed {
		logic       term;
		logic [5:0] sym;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	function automatic logic [5:0] symbol_value(input logic [6:0] c);
		logic [6:0] v;
		v = SYM_PLUS;
		if (c == CHAR_PLUS)
			v = SYM_PLUS;
		else if (c == CHAR_MINUS)
			v = SYM_MINUS;
		else if (c >= CHAR_ZERO && c <= CHAR_NINE)
			v = c - CHAR_ZERO + SYM_DIGIT_BASE;
		else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			v = c - CHAR_UPPER_A + SYM_UPPER_BASE;
		else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
			v = c - CHAR_LOWER_A + SYM_LOWER_BASE;
		return v[5:0];
	endfunction

endpackage

// File: rtl/sbtsd_if.sv
// Channel interfaces: character input, result output and configuration write.
interface sbtsd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface sbtsd_res_if import sbtsd_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           end_of_data;
	logic [COUNT_WIDTH-1:0]         sample_count;
	logic                           overflow;
	modport source (output valid, output sample, output end_of_data,
		output sample_count, output overflow, input ready);
	modport sink (input valid, input sample, input end_of_data,
		input sample_count, input overflow, output ready);
endinterface

interface sbtsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] difference_order;
	modport source (output valid, output difference_order, input ready);
	modport sink (input valid, input difference_order, output ready);
endinterface

// File: rtl/sbtsd_front.sv
// Front end: accepts characters, drops line breaks, classifies the rest.
module sbtsd_front import sbtsd_pkg::*; (
	sbtsd_char_if.sink chars,
	input  q_status_t  status,
	output logic       push,
	output q_entry_t   entry
);

	logic skip;

	always_comb begin
		skip = 1'b0;
		entry.term = 1'b0;
		entry.sym = symbol_value(chars.char_code[6:0]);
		unique case (chars.char_code) inside
			CHAR_LF, CHAR_CR: begin
				skip = 1'b1;
			end
			CHAR_NUL, CHAR_SPACE: begin
				entry.term = 1'b1;
			end
			default: begin
				skip = 1'b0;
			end
		endcase
	end

	// Line breaks are taken but never queued
	assign chars.ready = !status.full;
	assign push = chars.valid && !status.full && !skip;

endmodule

// File: rtl/sbtsd_queue.sv
// Short FIFO of classified items between the front and back ends.
`include "assert_macros.svh"
module sbtsd_queue import sbtsd_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_entry_t  pop_data,
	output q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Pointers wrap naturally: depth must be a power of two; the block does not check it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign status.full = (count_q == CW'(DEPTH));
	assign status.valid = (count_q != '0);

	`ASSERT_NEVER(queue_overfill, clk, arst_n, count_q > CW'(DEPTH))
	`ASSERT_NEVER(push_into_full, clk, arst_n, push && status.full)
	`ASSERT_AT(pop_needs_data, clk, arst_n, pop |-> count_q != '0)

endmodule

// File: rtl/sbtsd_back.sv
// Back end: assembles samples, undoes differencing, holds the result register.
`include "assert_macros.svh"
module sbtsd_back import sbtsd_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	sbtsd_cfg_if.sink    cfg,
	input  q_status_t    status,
	input  q_entry_t     q_data,
	output logic         pop,
	sbtsd_res_if.source  results
);

	localparam int MW = SAMPLE_WIDTH - 1;

	logic [1:0]             order_q;
	logic [MW-1:0]          acc_q;
	logic                   neg_q;
	logic                   in_sample_q;
	logic                   sat_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   valid_s1;
	logic                   term_s1;
	logic                   neg_s1;
	logic [MW-1:0]          mag_s1;
	logic                   sat_s1;
	logic [COUNT_WIDTH-1:0] count_s1;

	logic [SAMPLE_WIDTH-1:0] first_sum_q;
	logic                    valid_s2;
	logic                    term_s2;
	logic [SAMPLE_WIDTH-1:0] value_s2;
	logic                    sat_s2;
	logic [COUNT_WIDTH-1:0]  count_s2;

	logic [SAMPLE_WIDTH-1:0] second_sum_q;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                    out_end_q;
	logic [COUNT_WIDTH-1:0]  out_count_q;
	logic                    out_ovf_q;

	logic                    adv;
	logic                    done;
	logic [MW+4:0]           ext;
	logic                    wide_over;
	logic [MW-1:0]           mag_n;
	logic                    neg_n;
	logic                    sat_n;
	logic [COUNT_WIDTH-1:0]  count_inc;
	logic [SAMPLE_WIDTH-1:0] mag_ext;
	logic [SAMPLE_WIDTH-1:0] raw;
	logic [SAMPLE_WIDTH-1:0] sum1_n;
	logic [SAMPLE_WIDTH-1:0] sum2_n;

	// Whole back pipeline moves together when the result register can take data
	assign adv = !out_valid_q || results.ready;
	assign pop = adv && status.valid;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= '0;
		else if (cfg.valid)
			order_q <= cfg.difference_order;
	end

	// Stage 1: magnitude assembly
	assign ext = {acc_q, q_data.sym[4:0]};
	assign wide_over = |ext[MW+4:MW];
	assign done = !q_data.sym[CONT_POS];
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;

	always_comb begin
		if (!in_sample_q) begin
			mag_n = {{(MW-4){1'b0}}, q_data.sym[3:0]};
			neg_n = q_data.sym[SIGN_POS];
			sat_n = 1'b0;
		end else begin
			mag_n = wide_over ? {MW{1'b1}} : ext[MW-1:0];
			neg_n = neg_q;
			sat_n = sat_q || wide_over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			neg_q <= 1'b0;
			in_sample_q <= 1'b0;
			sat_q <= 1'b0;
			count_q <= '0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop && (q_data.term || done);
			if (pop) begin
				if (q_data.term || done) begin
					acc_q <= '0;
					neg_q <= 1'b0;
					sat_q <= 1'b0;
					in_sample_q <= 1'b0;
					count_q <= q_data.term ? '0 : count_inc;
				end else begin
					acc_q <= mag_n;
					neg_q <= neg_n;
					sat_q <= sat_n;
					in_sample_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pop) begin
			term_s1 <= q_data.term;
			neg_s1 <= q_data.term ? 1'b0 : neg_n;
			mag_s1 <= q_data.term ? '0 : mag_n;
			sat_s1 <= q_data.term ? 1'b0 : sat_n;
			count_s1 <= q_data.term ? count_q : count_inc;
		end
	end

	// Stage 2: sign and first running sum
	assign mag_ext = {1'b0, mag_s1};
	assign raw = neg_s1 ? ('0 - mag_ext) : mag_ext;
	assign sum1_n = neg_s1 ? (first_sum_q - mag_ext) : (first_sum_q + mag_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (term_s1)
					first_sum_q <= '0;
				else if (order_q != 2'd0)
					first_sum_q <= sum1_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			term_s2 <= term_s1;
			sat_s2 <= sat_s1;
			count_s2 <= count_s1;
			if (term_s1)
				value_s2 <= '0;
			else
				value_s2 <= (order_q == 2'd0) ? raw : sum1_n;
		end
	end

	// Stage 3: second running sum into the result register
	assign sum2_n = second_sum_q + value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				if (term_s2)
					second_sum_q <= '0;
				else if (order_q[1])
					second_sum_q <= sum2_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			out_end_q <= term_s2;
			out_ovf_q <= sat_s2;
			out_count_q <= count_s2;
			if (term_s2)
				out_sample_q <= '0;
			else
				out_sample_q <= order_q[1] ? sum2_n : value_s2;
		end
	end

	assign results.valid = out_valid_q;
	assign results.sample = out_sample_q;
	assign results.end_of_data = out_end_q;
	assign results.sample_count = out_count_q;
	assign results.overflow = out_ovf_q;

	`ASSERT_AT(end_item_clean, clk, arst_n,
		out_valid_q && out_end_q |-> out_sample_q == '0 && !out_ovf_q)
	`ASSERT_AT(term_clears_stream, clk, arst_n,
		pop && q_data.term |=> count_q == '0 && !in_sample_q && acc_q == '0)
	`ASSERT_AT(held_result_stalls_pipe, clk, arst_n,
		out_valid_q && !results.ready |-> !pop)

endmodule

// File: rtl/six_bit_text_sample_decoder.sv
// Top level of the six-bit text sample decoder: front end, queue, back end.
//
//  channel   modport  payload                                       handshake
//  chars     sink     char_code[7:0]                                valid/ready
//  results   source   sample, end_of_data, sample_count, overflow   valid/ready
//  cfg       sink     difference_order[1:0]                         valid/ready
//
// One character is taken per cycle; ready drops only while the item queue is
// full. After the queue, the character that closes a sample or end item
// passes through queue read and assembly, sign and first running sum, and
// second running sum into the result register. The back end advances
// whenever the result register is empty or being taken, so it sustains one
// item a cycle. A stalled result holds the back end; the queue then absorbs
// up to QUEUE_DEPTH queued items before ready falls. cfg.ready is always high.
// Reset (arst_n low) clears the accumulator, flags, count, both sums, the
// queue and difference_order; no clearing pass follows.
module six_bit_text_sample_decoder import sbtsd_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
	// queue depth: a power of two, two or more
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	sbtsd_cfg_if.sink   cfg,
	sbtsd_char_if.sink  chars,
	sbtsd_res_if.source results
);

	q_status_t q_status;
	q_entry_t  push_entry;
	q_entry_t  pop_entry;
	logic      push;
	logic      pop;

	// Classify each character; line breaks are consumed here and go no further
	sbtsd_front u_front (
		.chars  (chars),
		.status (q_status),
		.push   (push),
		.entry  (push_entry)
	);

	// Decouple character intake from result back-pressure
	sbtsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.pop_data  (pop_entry),
		.status    (q_status)
	);

	// Assemble, undifference and hold results until taken
	sbtsd_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.status  (q_status),
		.q_data  (pop_entry),
		.pop     (pop),
		.results (results)
	);

endmodule
